/* src/ffa_pkg.sv */
// ----------------------------------------------------------------------------
// ffa_pkg
// Types, constants and helpers for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int unsigned MaxBlocksDef  = 64;
  localparam int unsigned AlignBytesDef = 16;

  localparam logic [31:0] HeapBaseRst  = 32'h0020_0000;
  localparam logic [28:0] HeapSizeRst  = 29'h0010_0000;
  localparam logic [6:0]  HdrBytesRst  = 7'd12;
  localparam logic [28:0] MinHeap      = 29'd256;
  localparam logic [28:0] MaxHeap      = 29'h1000_0000;
  localparam logic [6:0]  MinHdr       = 7'd4;
  localparam logic [6:0]  MaxHdr       = 7'd64;

  localparam logic [1:0] CfgHeapBase = 2'd0;
  localparam logic [1:0] CfgHeapSize = 2'd1;
  localparam logic [1:0] CfgHdrBytes = 2'd2;

  typedef enum logic [1:0] {
    ActAlloc   = 2'd0,
    ActFree    = 2'd1,
    ActRealloc = 2'd2,
    ActNone    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNull    = 2'd1,
    StNoFit   = 2'd2,
    StInvalid = 2'd3
  } status_e;

  // one table entry as it moves along the chain
  typedef struct packed {
    logic        valid;
    logic        used;
    logic [27:0] offset;
    logic [27:0] size;
  } entry_t;

  // shift commands broadcast to every cell
  typedef struct packed {
    logic load;     // reinitialize
    logic wr;       // write entry at index idx
    logic ins;      // shift right above idx (insert at idx+1)
    logic del;      // shift left into idx (remove idx)
  } cell_cmd_t;

  typedef enum logic [3:0] {
    SIdle,
    SDecode,
    SScanAlloc,
    SSplit,
    SScanFind,
    SRelease,
    SMerge,
    SMergeDel,
    SReallocCheck,
    SReallocFind,
    SDone
  } state_e;

endpackage

/* src/ffa_if.sv */
// ----------------------------------------------------------------------------
// ffa_req_if / ffa_rsp_if / ffa_cfg_if
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [28:0] request_size;
  logic [31:0] block_address;
  modport source (output valid, action, request_size, block_address, input ready);
  modport sink   (input valid, action, request_size, block_address, output ready);
endinterface

interface ffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] granted_address;
  logic [1:0]  status;
  logic [28:0] used_bytes;
  logic [28:0] free_bytes;
  modport source (output valid, granted_address, status, used_bytes, free_bytes,
                  input ready);
  modport sink   (input valid, granted_address, status, used_bytes, free_bytes,
                  output ready);
endinterface

interface ffa_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/ffa_cell.sv */
// ----------------------------------------------------------------------------
// ffa_cell
// One table slot. Loads, writes, or takes its neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module ffa_cell #(
  parameter int unsigned IdxW = 6,
  parameter logic [IdxW-1:0] MyIdx = '0,
  parameter ffa_pkg::entry_t RstEnt = '0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ffa_pkg::cell_cmd_t cmd_i,
  input  logic [IdxW-1:0]    idx_i,
  input  ffa_pkg::entry_t    wr_i,
  input  ffa_pkg::entry_t    load_i,
  input  ffa_pkg::entry_t    left_i,
  input  ffa_pkg::entry_t    right_i,
  output ffa_pkg::entry_t    ent_o
);
  ffa_pkg::entry_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    priority if (cmd_i.load) begin
      ent_d = load_i;
    end else if (cmd_i.wr && idx_i == MyIdx) begin
      ent_d = wr_i;
    end else if (cmd_i.ins && MyIdx > idx_i) begin
      ent_d = left_i;
    end else if (cmd_i.del && MyIdx >= idx_i) begin
      ent_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= RstEnt;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;
endmodule

/* src/ffa_ctrl.sv */
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer: scans the cell row one entry per cycle and issues shift commands.
// ----------------------------------------------------------------------------
module ffa_ctrl #(
  parameter int unsigned MaxBlocks  = 64,
  parameter int unsigned AlignBytes = 16,
  parameter int unsigned IdxW       = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  logic [1:0]         action_i,
  input  logic [28:0]        request_size_i,
  input  logic [31:0]        block_address_i,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output logic [31:0]        granted_o,
  output logic [1:0]         status_o,
  output logic [28:0]        used_o,
  input  logic               reinit_i,
  input  logic [31:0]        base_addr_i,
  input  logic [6:0]         hdr_i,
  input  ffa_pkg::entry_t    sel_i,
  input  ffa_pkg::entry_t    nxt_i,
  output logic [IdxW-1:0]    idx_o,
  output ffa_pkg::cell_cmd_t cmd_o,
  output ffa_pkg::entry_t    wr_o,
  output logic               busy_o
);
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [CntW-1:0] Full = CntW'(MaxBlocks);
  localparam logic [CntW-1:0] One  = CntW'(1);

  ffa_pkg::state_e st_q, st_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [28:0]     used_q, used_d;
  logic [1:0]      act_q, act_d;
  logic [28:0]     rsz_q, rsz_d;
  logic [31:0]     addr_q, addr_d;
  logic [29:0]     asz_q, asz_d;
  logic [31:0]     gr_q, gr_d;
  logic [1:0]      stat_q, stat_d;
  logic            realloc_q, realloc_d;  // allocate step of a reallocate
  logic [28:0]     charge;
  logic [29:0]     rnd;
  logic [31:0]     paddr;
  logic [30:0]     need;
  logic            last;

  assign rnd    = ({1'b0, request_size_i} + 30'(AlignBytes - 1)) / 30'(AlignBytes)
                  * 30'(AlignBytes);
  assign paddr  = base_addr_i + {4'd0, sel_i.offset} + {25'd0, hdr_i};
  assign need   = {1'b0, asz_q} + {24'd0, hdr_i} + 31'(AlignBytes);
  assign charge = {1'b0, sel_i.size} + {22'd0, hdr_i};
  assign last   = ({1'b0, idx_q} + One) >= cnt_q;

  always_comb begin
    st_d = st_q; idx_d = idx_q; cnt_d = cnt_q; used_d = used_q;
    act_d = act_q; rsz_d = rsz_q; addr_d = addr_q; asz_d = asz_q;
    gr_d = gr_q; stat_d = stat_q; realloc_d = realloc_q;
    unique case (st_q)
      ffa_pkg::SIdle: begin
        if (req_valid_i) begin
          act_d = (action_i == ffa_pkg::ActRealloc && block_address_i == '0) ?
                  ffa_pkg::ActAlloc : action_i;
          rsz_d = request_size_i; addr_d = block_address_i; asz_d = rnd;
          gr_d = '0; stat_d = ffa_pkg::StNull; idx_d = '0; realloc_d = 1'b0;
          st_d = ffa_pkg::SDecode;
        end
      end
      ffa_pkg::SDecode: begin
        if (act_q == ffa_pkg::ActAlloc) begin
          st_d = (rsz_q == '0) ? ffa_pkg::SDone : ffa_pkg::SScanAlloc;
        end else if (act_q == ffa_pkg::ActFree || act_q == ffa_pkg::ActRealloc) begin
          st_d = (addr_q == '0) ? ffa_pkg::SDone : ffa_pkg::SScanFind;
        end else begin
          st_d = ffa_pkg::SDone;
        end
      end
      ffa_pkg::SScanAlloc: begin
        if (!sel_i.used && {2'b0, sel_i.size} >= asz_q) begin
          st_d = ffa_pkg::SSplit;
        end else if (last) begin
          stat_d = ffa_pkg::StNoFit; st_d = ffa_pkg::SDone;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ffa_pkg::SSplit: begin
        if ({3'b0, sel_i.size} >= need && cnt_q < Full) begin
          cnt_d = cnt_q + One;
          used_d = used_q + asz_q[28:0] + {22'd0, hdr_i};
        end else begin
          used_d = used_q + charge;
        end
        gr_d = paddr; stat_d = ffa_pkg::StOk;
        if (realloc_q) begin
          idx_d = '0; st_d = ffa_pkg::SReallocFind;
        end else begin
          st_d = ffa_pkg::SDone;
        end
      end
      ffa_pkg::SScanFind, ffa_pkg::SReallocFind: begin
        if (sel_i.used && paddr == addr_q) begin
          st_d = (st_q == ffa_pkg::SReallocFind) ? ffa_pkg::SRelease :
                 (act_q == ffa_pkg::ActRealloc && rsz_q != '0) ?
                 ffa_pkg::SReallocCheck : ffa_pkg::SRelease;
        end else if (last) begin
          if (st_q == ffa_pkg::SScanFind) stat_d = ffa_pkg::StInvalid;
          st_d = ffa_pkg::SDone;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ffa_pkg::SReallocCheck: begin
        if (sel_i.size >= rsz_q[27:0] && !rsz_q[28]) begin
          gr_d = addr_q; stat_d = ffa_pkg::StOk; st_d = ffa_pkg::SDone;
        end else begin
          realloc_d = 1'b1; idx_d = '0; st_d = ffa_pkg::SScanAlloc;
        end
      end
      ffa_pkg::SRelease: begin
        used_d = (used_q >= charge) ? used_q - charge : '0;
        if (!realloc_q) begin
          stat_d = (act_q == ffa_pkg::ActFree) ? ffa_pkg::StOk : ffa_pkg::StNull;
        end
        idx_d = '0; st_d = ffa_pkg::SMerge;
      end
      ffa_pkg::SMerge: begin
        if (last) begin
          st_d = ffa_pkg::SDone;
        end else if (!sel_i.used && !nxt_i.used) begin
          st_d = ffa_pkg::SMergeDel;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ffa_pkg::SMergeDel: begin
        cnt_d = cnt_q - One; st_d = ffa_pkg::SMerge;
      end
      ffa_pkg::SDone: begin
        if (rsp_ready_i) st_d = ffa_pkg::SIdle;
      end
      default: st_d = ffa_pkg::SIdle;
    endcase
    if (reinit_i) begin
      cnt_d = One; used_d = '0;
    end
  end

  always_comb begin
    cmd_o = '0;
    wr_o  = sel_i;
    unique case (st_q)
      ffa_pkg::SSplit: begin
        if ({3'b0, sel_i.size} >= need && cnt_q < Full) begin
          cmd_o.ins = 1'b1;
          wr_o.size = asz_q[27:0];
        end
        cmd_o.wr = 1'b1; wr_o.used = 1'b1;
      end
      ffa_pkg::SRelease: begin
        cmd_o.wr = 1'b1; wr_o.used = 1'b0;
      end
      ffa_pkg::SMergeDel: begin
        // idx absorbs idx+1, the entries above move down one
        cmd_o.wr = 1'b1; cmd_o.del = 1'b1;
        wr_o.size = sel_i.size + 28'(hdr_i) + nxt_i.size;
      end
      default: ;
    endcase
    cmd_o.load = reinit_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ffa_pkg::SIdle; idx_q <= '0; cnt_q <= One; used_q <= '0;
      realloc_q <= 1'b0;
    end else begin
      st_q <= st_d; idx_q <= idx_d; cnt_q <= cnt_d; used_q <= used_d;
      realloc_q <= realloc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d; rsz_q <= rsz_d; addr_q <= addr_d; asz_q <= asz_d;
    gr_q <= gr_d; stat_q <= stat_d;
  end

  assign req_ready_o = (st_q == ffa_pkg::SIdle);
  assign rsp_valid_o = (st_q == ffa_pkg::SDone);
  assign granted_o   = gr_q;
  assign status_o    = stat_q;
  assign used_o      = used_q;
  assign idx_o       = idx_q;
  assign busy_o      = (st_q != ffa_pkg::SIdle);
endmodule

/* src/first_fit_heap_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a row of table cells with split and coalescing.
// ----------------------------------------------------------------------------
// The controller walks the cell row one entry a cycle for the address search,
// the first-fit scan, the old-block search and the merge pass; the merge pass
// holds its index for each pair that it joins. One request in flight; the
// next is taken in the cycle after the response is accepted, at the earliest.
// Reset and any base, size or header write: one free block covering the heap.
module first_fit_heap_allocator #(
  parameter int unsigned MaxBlocks  = ffa_pkg::MaxBlocksDef,
  parameter int unsigned AlignBytes = ffa_pkg::AlignBytesDef
) (
  input logic      clk_i,
  input logic      rst_ni,
  ffa_req_if.sink  req_i,
  ffa_rsp_if.source rsp_o,
  ffa_cfg_if.sink  cfg_i
);
  localparam int unsigned IdxW = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam ffa_pkg::entry_t RstEnt0 = '{valid: 1'b1, used: 1'b0, offset: 28'd0,
    size: 28'(ffa_pkg::HeapSizeRst - {22'd0, ffa_pkg::HdrBytesRst})};

  logic [31:0] base_q;
  logic [28:0] size_q;
  logic [6:0]  hdr_q;
  logic [28:0] csize;
  logic [6:0]  chdr;
  logic        cfg_we, busy;

  ffa_pkg::entry_t    ent [MaxBlocks];
  ffa_pkg::entry_t    sel, nxt, wr, load0, blank, rem;
  ffa_pkg::cell_cmd_t cmd;
  logic [IdxW-1:0]    idx;
  logic [28:0]        used;

  assign cfg_i.ready = 1'b1;
  assign cfg_we = cfg_i.valid;

  always_comb begin
    csize = cfg_i.data[28:0];
    if (csize < ffa_pkg::MinHeap) csize = ffa_pkg::MinHeap;
    if (csize > ffa_pkg::MaxHeap) csize = ffa_pkg::MaxHeap;
    chdr = cfg_i.data[6:0];
    if (chdr < ffa_pkg::MinHdr) chdr = ffa_pkg::MinHdr;
    if (chdr > ffa_pkg::MaxHdr) chdr = ffa_pkg::MaxHdr;
  end

  logic reinit;
  logic [28:0] nsize;
  logic [6:0]  nhdr;
  assign reinit = cfg_we && (cfg_i.index == ffa_pkg::CfgHeapBase ||
                             cfg_i.index == ffa_pkg::CfgHeapSize ||
                             cfg_i.index == ffa_pkg::CfgHdrBytes);
  assign nsize = (cfg_we && cfg_i.index == ffa_pkg::CfgHeapSize) ? csize : size_q;
  assign nhdr  = (cfg_we && cfg_i.index == ffa_pkg::CfgHdrBytes) ? chdr : hdr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= ffa_pkg::HeapBaseRst;
      size_q <= ffa_pkg::HeapSizeRst;
      hdr_q  <= ffa_pkg::HdrBytesRst;
    end else if (cfg_we) begin
      unique case (cfg_i.index)
        ffa_pkg::CfgHeapBase: base_q <= cfg_i.data;
        ffa_pkg::CfgHeapSize: size_q <= csize;
        ffa_pkg::CfgHdrBytes: hdr_q  <= chdr;
        default: ;
      endcase
    end
  end

  always_comb begin
    blank = '0;
    load0 = '0;
    load0.valid = 1'b1;
    load0.size  = 28'(nsize - {22'd0, nhdr});
  end

  // split remainder lands in idx+1 while the row shifts up
  always_comb begin
    rem        = '0;
    rem.valid  = 1'b1;
    rem.offset = sel.offset + 28'(hdr_q) + wr.size;
    rem.size   = sel.size - wr.size - 28'(hdr_q);
  end

  for (genvar g = 0; g < MaxBlocks; g++) begin : g_cell
    ffa_pkg::entry_t lft, rgt;
    if (g == 0) begin : g_l
      assign lft = blank;
    end else begin : g_l
      assign lft = (cmd.ins && idx == IdxW'(g - 1)) ? rem : ent[g-1];
    end
    if (g == MaxBlocks - 1) begin : g_r
      assign rgt = blank;
    end else begin : g_r
      assign rgt = ent[g+1];
    end
    ffa_cell #(
      .IdxW(IdxW), .MyIdx(IdxW'(g)),
      .RstEnt((g == 0) ? RstEnt0 : ffa_pkg::entry_t'('0))
    ) u_cell (
      .clk_i, .rst_ni, .cmd_i(cmd), .idx_i(idx), .wr_i(wr),
      .load_i((g == 0) ? load0 : blank), .left_i(lft), .right_i(rgt),
      .ent_o(ent[g])
    );
  end

  logic [IdxW-1:0] idx1;
  assign idx1 = idx + 1'b1;
  assign sel = ent[idx];
  assign nxt = ({1'b0, idx} + 1 < MaxBlocks) ? ent[idx1] : blank;

  ffa_ctrl #(.MaxBlocks(MaxBlocks), .AlignBytes(AlignBytes), .IdxW(IdxW)) u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i(req_i.valid), .req_ready_o(req_i.ready),
    .action_i(req_i.action), .request_size_i(req_i.request_size),
    .block_address_i(req_i.block_address),
    .rsp_valid_o(rsp_o.valid), .rsp_ready_i(rsp_o.ready),
    .granted_o(rsp_o.granted_address), .status_o(rsp_o.status), .used_o(used),
    .reinit_i(reinit), .base_addr_i(base_q), .hdr_i(hdr_q),
    .sel_i(sel), .nxt_i(nxt), .idx_o(idx), .cmd_o(cmd), .wr_o(wr),
    .busy_o(busy)
  );

  assign rsp_o.used_bytes = used;
  assign rsp_o.free_bytes = (used <= size_q) ? size_q - used : '0;

  a_one_hot_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd.ins, cmd.del}) <= 1) else $error("ins and del together");
  a_rsp_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> busy) else $error("response while idle");
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> used <= size_q) else $error("used exceeds heap");
endmodule

/* test/ffa_checker.sv */
// ----------------------------------------------------------------------------
// ffa_checker
// Watches the request, response and register channels of the first-fit heap
// allocator, keeps its own copy of the block table, and compares every
// response with the oldest predicted one.
// ----------------------------------------------------------------------------
module ffa_checker (
  input  logic clk_i,
  input  logic rst_ni,
  ffa_req_if   req_i,
  ffa_rsp_if   rsp_i,
  ffa_cfg_if   cfg_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NBlk = ffa_pkg::MaxBlocksDef;
  localparam int unsigned Algn = ffa_pkg::AlignBytesDef;

  typedef struct {
    logic [31:0]      granted;
    ffa_pkg::status_e status;
    logic [28:0]      used;
    logic [28:0]      free;
  } alloc_rsp_t;

  logic [31:0] base_addr;
  int unsigned region_bytes;
  int unsigned hdr_bytes;
  int unsigned blk_off  [NBlk];
  int unsigned blk_size [NBlk];
  bit          blk_used [NBlk];
  int unsigned blk_cnt;
  int unsigned used_cnt;
  int          fails;
  alloc_rsp_t  rsp_q[$];

  function automatic void table_init();
    for (int k = 0; k < NBlk; k++) begin
      blk_off[k] = 0;
      blk_size[k] = 0;
      blk_used[k] = 0;
    end
    blk_size[0] = region_bytes - hdr_bytes;
    blk_cnt = 1;
    used_cnt = 0;
  endfunction

  function automatic logic [31:0] payload_at(int unsigned i);
    return base_addr + blk_off[i] + hdr_bytes;
  endfunction

  function automatic int unsigned find_owner(logic [31:0] addr);
    for (int unsigned i = 0; i < blk_cnt; i++)
      if (blk_used[i] && payload_at(i) == addr) return i;
    return NBlk;
  endfunction

  function automatic void coalesce();
    int unsigned i;
    i = 0;
    while (i + 1 < blk_cnt) begin
      if (!blk_used[i] && !blk_used[i+1]) begin
        blk_size[i] += hdr_bytes + blk_size[i+1];
        for (int unsigned k = i + 1; k + 1 < blk_cnt; k++) begin
          blk_off[k] = blk_off[k+1];
          blk_size[k] = blk_size[k+1];
          blk_used[k] = blk_used[k+1];
        end
        blk_cnt--;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic void release_blk(int unsigned i);
    int unsigned charge;
    charge = blk_size[i] + hdr_bytes;
    blk_used[i] = 0;
    used_cnt = (used_cnt >= charge) ? used_cnt - charge : 0;
    coalesce();
  endfunction

  function automatic ffa_pkg::status_e first_fit(int unsigned want,
                                                 output logic [31:0] addr);
    longint unsigned sz;
    sz = ((longint'(want) + Algn - 1) / Algn) * Algn;
    addr = '0;
    for (int unsigned i = 0; i < blk_cnt; i++) begin
      if (!blk_used[i] && longint'(blk_size[i]) >= sz) begin
        if (longint'(blk_size[i]) >= sz + hdr_bytes + Algn && blk_cnt < NBlk) begin
          for (int unsigned k = blk_cnt; k > i + 1; k--) begin
            blk_off[k] = blk_off[k-1];
            blk_size[k] = blk_size[k-1];
            blk_used[k] = blk_used[k-1];
          end
          blk_off[i+1] = blk_off[i] + hdr_bytes + int'(sz);
          blk_size[i+1] = blk_size[i] - int'(sz) - hdr_bytes;
          blk_used[i+1] = 0;
          blk_size[i] = int'(sz);
          blk_cnt++;
        end
        blk_used[i] = 1;
        used_cnt += blk_size[i] + hdr_bytes;
        addr = payload_at(i);
        return ffa_pkg::StOk;
      end
    end
    return ffa_pkg::StNoFit;
  endfunction

  function automatic alloc_rsp_t predict(ffa_pkg::action_e act, int unsigned want,
                                         logic [31:0] addr);
    alloc_rsp_t r;
    int unsigned i;
    logic [31:0] g;
    r.granted = '0;
    r.status = ffa_pkg::StNull;
    if (act == ffa_pkg::ActRealloc && addr == 0) act = ffa_pkg::ActAlloc;
    if (act == ffa_pkg::ActAlloc) begin
      if (want != 0) r.status = first_fit(want, r.granted);
    end else if (act == ffa_pkg::ActFree || (act == ffa_pkg::ActRealloc && want == 0)) begin
      if (addr != 0) begin
        i = find_owner(addr);
        if (i >= NBlk) r.status = ffa_pkg::StInvalid;
        else begin
          release_blk(i);
          r.status = (act == ffa_pkg::ActFree) ? ffa_pkg::StOk : ffa_pkg::StNull;
        end
      end
    end else if (act == ffa_pkg::ActRealloc) begin
      i = find_owner(addr);
      if (i >= NBlk) r.status = ffa_pkg::StInvalid;
      else if (blk_size[i] >= want) begin
        r.granted = addr;
        r.status = ffa_pkg::StOk;
      end else begin
        r.status = first_fit(want, g);
        r.granted = g;
        if (r.status == ffa_pkg::StOk) begin
          i = find_owner(addr);
          if (i < NBlk) release_blk(i);
        end
      end
    end
    r.used = used_cnt[28:0];
    r.free = (used_cnt <= region_bytes) ? 29'(region_bytes - used_cnt) : '0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_rsp_t e;
    if (!rst_ni) begin
      base_addr = ffa_pkg::HeapBaseRst;
      region_bytes = ffa_pkg::HeapSizeRst;
      hdr_bytes = ffa_pkg::HdrBytesRst;
      table_init();
      rsp_q.delete();
      fails = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == ffa_pkg::CfgHeapBase) begin
          base_addr = cfg_i.data;
          table_init();
        end else if (cfg_i.index == ffa_pkg::CfgHeapSize) begin
          region_bytes = cfg_i.data[28:0];
          if (region_bytes < ffa_pkg::MinHeap) region_bytes = ffa_pkg::MinHeap;
          if (region_bytes > ffa_pkg::MaxHeap) region_bytes = ffa_pkg::MaxHeap;
          table_init();
        end else if (cfg_i.index == ffa_pkg::CfgHdrBytes) begin
          hdr_bytes = cfg_i.data[6:0];
          if (hdr_bytes < ffa_pkg::MinHdr) hdr_bytes = ffa_pkg::MinHdr;
          if (hdr_bytes > ffa_pkg::MaxHdr) hdr_bytes = ffa_pkg::MaxHdr;
          table_init();
        end
      end
      if (req_i.valid && req_i.ready)
        rsp_q.push_back(predict(ffa_pkg::action_e'(req_i.action), req_i.request_size,
                                req_i.block_address));
      if (rsp_i.valid && rsp_i.ready) begin
        if (rsp_q.size() == 0) begin
          $error("unexpected response granted_address=%h", rsp_i.granted_address);
          fails++;
        end else begin
          e = rsp_q.pop_front();
          if (rsp_i.granted_address !== e.granted) begin
            $error("granted_address exp %h got %h", e.granted, rsp_i.granted_address);
            fails++;
          end
          if (rsp_i.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, rsp_i.status);
            fails++;
          end
          if (rsp_i.used_bytes !== e.used) begin
            $error("used_bytes exp %0d got %0d", e.used, rsp_i.used_bytes);
            fails++;
          end
          if (rsp_i.free_bytes !== e.free) begin
            $error("free_bytes exp %0d got %0d", e.free, rsp_i.free_bytes);
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o <= rsp_q.size();
  end

endmodule

/* test/first_fit_heap_allocator_tb.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Drives allocate, free, reallocate and no-action requests with random gaps and back
// pressure across several heap settings; the checker judges every response.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 4 * ffa_pkg::MaxBlocksDef + 64;
  localparam logic [1:0] CfgUnused = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  bit   idle_on = 1'b1;
  bit   hold_req = 1'b0;
  logic [31:0] addr_pool[$];

  ffa_req_if req_if();
  ffa_rsp_if rsp_if();
  ffa_cfg_if cfg_if();

  first_fit_heap_allocator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  ffa_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    req_if.valid = 1'b0;
    req_if.action = ffa_pkg::ActAlloc;
    req_if.request_size = '0;
    req_if.block_address = '0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = ffa_pkg::CfgHeapBase;
    cfg_if.data = '0;
  end

  // granted addresses feed later free and reallocate requests
  always @(posedge clk_i) begin
    if (rsp_if.valid && rsp_if.ready && rsp_if.granted_address != 0) begin
      addr_pool.push_back(rsp_if.granted_address);
      if (addr_pool.size() > 80) void'(addr_pool.pop_front());
    end
  end

  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = idle_on ? $urandom_range(0, 13) : 0;
      if (hold_req) begin
        gap = 3000;
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  task automatic send_req(ffa_pkg::action_e act, logic [28:0] sz, logic [31:0] addr);
    int gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.action <= act;
    req_if.request_size <= sz;
    req_if.block_address <= addr;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_addr();
    if (addr_pool.size() == 0 || $urandom_range(0, 9) == 0) return $urandom();
    return addr_pool[$urandom_range(0, addr_pool.size() - 1)];
  endfunction

  function automatic logic [28:0] pick_size();
    case ($urandom_range(0, 19))
      0:       return 29'($urandom());
      1:       return 29'($urandom_range(0, 32'h0010_0000));
      2, 3:    return 29'($urandom_range(0, 4096));
      default: return 29'($urandom_range(1, 300));
    endcase
  endfunction

  task automatic random_run(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 50) send_req(ffa_pkg::ActAlloc, pick_size(), $urandom());
      else if (r < 78) send_req(ffa_pkg::ActFree, pick_size(), pick_addr());
      else if (r < 97) send_req(ffa_pkg::ActRealloc, pick_size(), pick_addr());
      else if (r < 98) send_req(ffa_pkg::ActRealloc, pick_size(), '0);
      else send_req(ffa_pkg::ActNone, pick_size(), pick_addr());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_req(ffa_pkg::ActAlloc, 29'd0, '0);
    send_req(ffa_pkg::ActAlloc, 29'd1, '0);
    send_req(ffa_pkg::ActAlloc, 29'd16, '0);
    send_req(ffa_pkg::ActAlloc, 29'd17, '0);
    send_req(ffa_pkg::ActAlloc, 29'h1FFF_FFFF, '1);
    send_req(ffa_pkg::ActAlloc, 29'h1000_0000, '0);
    send_req(ffa_pkg::ActFree, 29'd0, '0);
    send_req(ffa_pkg::ActFree, '1, 32'hDEAD_BEEF);
    drain();
    send_req(ffa_pkg::ActFree, 29'd0, addr_pool[0]);
    send_req(ffa_pkg::ActRealloc, 29'd40, '0);
    send_req(ffa_pkg::ActRealloc, 29'd5, 32'h1234_5678);
    drain();
    send_req(ffa_pkg::ActRealloc, 29'd8, addr_pool[$]);
    send_req(ffa_pkg::ActRealloc, 29'd500, addr_pool[$]);
    drain();
    send_req(ffa_pkg::ActRealloc, 29'h1FFF_FFFF, addr_pool[$]);
    send_req(ffa_pkg::ActRealloc, 29'd0, addr_pool[$]);
    send_req(ffa_pkg::ActRealloc, 29'd0, 32'h0000_0004);
    send_req(ffa_pkg::ActNone, '1, '1);
    for (int k = 0; k < 66; k++) send_req(ffa_pkg::ActAlloc, 29'd16, '0);
    drain();

    random_run(150);
    hold_req = 1'b1;
    random_run(100);
    drain();
    write_reg(ffa_pkg::CfgHeapSize, 32'd0);
    write_reg(ffa_pkg::CfgHdrBytes, 32'd0);
    random_run(100);
    drain();
    write_reg(ffa_pkg::CfgHeapBase, 32'hFFFF_FF00);
    write_reg(ffa_pkg::CfgHeapSize, 32'hFFFF_FFFF);
    write_reg(ffa_pkg::CfgHdrBytes, 32'd127);
    random_run(150);
    drain();
    write_reg(ffa_pkg::CfgHeapBase, 32'd0);
    write_reg(ffa_pkg::CfgHeapSize, 32'd4096);
    write_reg(ffa_pkg::CfgHdrBytes, 32'd64);
    random_run(120);
    drain();
    write_reg(CfgUnused, 32'h5555_5555);
    write_reg(ffa_pkg::CfgHeapBase, $urandom());
    write_reg(ffa_pkg::CfgHeapSize, 32'h1000_0000);
    write_reg(ffa_pkg::CfgHdrBytes, 32'd4);
    random_run(150);
    drain();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* first_fit_heap_allocator.f */
src/ffa_pkg.sv
src/ffa_if.sv
src/ffa_cell.sv
src/ffa_ctrl.sv
src/first_fit_heap_allocator.sv
test/ffa_checker.sv
test/first_fit_heap_allocator_tb.sv
